// ===== src/ffba_pkg.sv =====
package ffba_pkg;

    localparam int DEFAULT_POOL_UNITS = 1024;
    localparam int CNT_W = 11;
    localparam int ADDR_W = 32;
    localparam int WORD_BITS = 32;
    localparam int WB_W = 5;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE = 1'b1;

    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_NOSPACE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_MARK,
        ST_RESP
    } state_t;

endpackage

// ===== src/first_fit_bitmap_allocator_core.sv =====
// Sequence: accept, one setup state, a scan of the map words in order (one
// map word per cycle from the memory port), a mark pass over each word the run spans,
// and a write into the output register once that register is free.
// Throughput: one transaction at a time; free requests skip the scan.
// Reset: aresetn is synchronous and active low. After reset a clearing pass writes zero
// to every map word, during which no request is taken.
module first_fit_bitmap_allocator_core #(
    parameter int POOL_UNITS = ffba_pkg::DEFAULT_POOL_UNITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_command,
    input  logic [ffba_pkg::CNT_W-1:0]  s_unit_count,
    input  logic [ffba_pkg::ADDR_W-1:0] s_free_address,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_status,
    output logic [ffba_pkg::ADDR_W-1:0] m_run_address,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ffba_pkg::ADDR_W-1:0] cfg_data
);

    localparam int WORD_BITS = ffba_pkg::WORD_BITS;
    localparam int WB_W = ffba_pkg::WB_W;
    localparam int NUM_WORDS = (POOL_UNITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int POS_W = $clog2(POOL_UNITS + 1);
    localparam int CW = (POS_W > ffba_pkg::CNT_W) ? POS_W + 1 : ffba_pkg::CNT_W + 1;
    localparam logic [CW-1:0] POOL_C = CW'(POOL_UNITS);
    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NUM_WORDS - 1);

    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [WORD_BITS-1:0] mem_rdata_reg;
    logic                 mem_re;
    logic [WADDR_W-1:0]   mem_raddr;
    logic                 mem_we;
    logic [WADDR_W-1:0]   mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    ffba_pkg::state_t state_reg, state_next;
    logic [WADDR_W-1:0]        ptr_reg, ptr_next;
    logic [WADDR_W-1:0]        last_word_reg, last_word_next;
    logic                      rd_act_reg, rd_act_next;
    logic                      dv_reg, dv_next;
    logic [WADDR_W-1:0]        dw_reg, dw_next;
    logic [CW-1:0]             carry_reg, carry_next;
    logic                      cmd_reg, cmd_next;
    logic [ffba_pkg::CNT_W-1:0] count_reg, count_next;
    logic [ffba_pkg::ADDR_W-1:0] off_reg, off_next;
    logic [CW-1:0]             start_reg, start_next;
    logic [CW-1:0]             end_reg, end_next;
    logic                      set_reg, set_next;
    logic                      status_reg, status_next;
    logic [ffba_pkg::ADDR_W-1:0] base_reg, base_next;
    logic                      m_valid_reg, m_valid_next;
    logic                      m_status_reg, m_status_next;
    logic [ffba_pkg::ADDR_W-1:0] m_addr_reg, m_addr_next;

    logic [CW-1:0]        count_ext;
    logic [CW-1:0]        eff_count;
    logic [WORD_BITS-1:0] busy_eff;
    logic [CW-1:0]        run_v [WORD_BITS];
    logic [WORD_BITS-1:0] hit_v;
    logic [WB_W-1:0]      hit_sel;
    logic                 scan_hit;
    logic [CW-1:0]        scan_start;
    logic [WORD_BITS-1:0] mark_mask;
    logic [CW-1:0]        free_start;
    logic [CW-1:0]        free_end_raw;
    logic [CW-1:0]        free_end;
    logic [CW-1:0]        free_last;
    logic [CW-1:0]        alloc_end;
    logic [CW-1:0]        alloc_last;
    logic                 free_skip;
    logic                 out_free;

    assign count_ext = CW'(count_reg);
    // A zero count looks for the first free unit, the same position a count of one finds.
    assign eff_count = (count_reg == '0) ? CW'(1) : count_ext;
    assign out_free = !m_valid_reg || m_ready;

    assign free_skip = (off_reg >= ffba_pkg::ADDR_W'(POOL_UNITS)) || (count_reg == '0);
    assign free_start = CW'(off_reg);
    assign free_end_raw = free_start + count_ext;
    assign free_end = (free_end_raw > POOL_C) ? POOL_C : free_end_raw;
    assign free_last = free_end - CW'(1);
    assign alloc_end = scan_start + count_ext;
    assign alloc_last = alloc_end - CW'(1);

    // Run length of free units ending at each bit of the word on the read port.
    always_comb begin
        logic                 hb;
        logic [WB_W-1:0]      p;
        logic [CW-1:0]        g;
        for (int b = 0; b < WORD_BITS; b++) begin
            g = CW'({dw_reg, WB_W'(b)});
            busy_eff[b] = mem_rdata_reg[b] | (g >= POOL_C);
            mark_mask[b] = (g >= start_reg) && (g < end_reg);
        end
        for (int i = 0; i < WORD_BITS; i++) begin
            hb = 1'b0;
            p = '0;
            for (int j = 0; j < WORD_BITS; j++) begin
                if (j <= i && busy_eff[j]) begin
                    hb = 1'b1;
                    p = WB_W'(j);
                end
            end
            if (hb) begin
                run_v[i] = CW'(i) - CW'(p);
            end else begin
                run_v[i] = carry_reg + CW'(i + 1);
            end
            hit_v[i] = run_v[i] >= eff_count;
        end
        hit_sel = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (hit_v[i]) begin
                hit_sel = WB_W'(i);
            end
        end
        scan_hit = |hit_v;
        scan_start = CW'({dw_reg, hit_sel}) + CW'(1) - eff_count;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ffba_pkg::ST_CLEAR: begin
                if (ptr_reg == LAST_WORD) begin
                    state_next = ffba_pkg::ST_IDLE;
                end
            end
            ffba_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = ffba_pkg::ST_PREP;
                end
            end
            ffba_pkg::ST_PREP: begin
                if (cmd_reg == ffba_pkg::CMD_ALLOC) begin
                    state_next = (count_ext > POOL_C) ? ffba_pkg::ST_RESP : ffba_pkg::ST_SCAN;
                end else begin
                    state_next = free_skip ? ffba_pkg::ST_RESP : ffba_pkg::ST_MARK;
                end
            end
            ffba_pkg::ST_SCAN: begin
                if (dv_reg) begin
                    if (scan_hit) begin
                        state_next = (count_reg == '0) ? ffba_pkg::ST_RESP : ffba_pkg::ST_MARK;
                    end else if (dw_reg == LAST_WORD) begin
                        state_next = ffba_pkg::ST_RESP;
                    end
                end
            end
            ffba_pkg::ST_MARK: begin
                if (dv_reg && dw_reg == last_word_reg) begin
                    state_next = ffba_pkg::ST_RESP;
                end
            end
            ffba_pkg::ST_RESP: begin
                if (out_free) begin
                    state_next = ffba_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ffba_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        mem_re = 1'b0;
        mem_raddr = ptr_reg;
        mem_we = 1'b0;
        mem_waddr = dw_reg;
        mem_wdata = '0;
        case (state_reg)
            ffba_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                mem_waddr = ptr_reg;
            end
            ffba_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            ffba_pkg::ST_SCAN: begin
                mem_re = rd_act_reg;
            end
            ffba_pkg::ST_MARK: begin
                mem_re = rd_act_reg;
                mem_we = dv_reg;
                mem_wdata = set_reg ? (mem_rdata_reg | mark_mask)
                                    : (mem_rdata_reg & ~mark_mask);
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        ptr_next = ptr_reg;
        last_word_next = last_word_reg;
        rd_act_next = rd_act_reg;
        dv_next = 1'b0;
        dw_next = ptr_reg;
        carry_next = carry_reg;
        cmd_next = cmd_reg;
        count_next = count_reg;
        off_next = off_reg;
        start_next = start_reg;
        end_next = end_reg;
        set_next = set_reg;
        status_next = status_reg;
        base_next = cfg_valid ? cfg_data : base_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_addr_next = m_addr_reg;
        case (state_reg)
            ffba_pkg::ST_CLEAR: begin
                if (ptr_reg != LAST_WORD) begin
                    ptr_next = ptr_reg + WADDR_W'(1);
                end
            end
            ffba_pkg::ST_IDLE: begin
                cmd_next = s_command;
                count_next = s_unit_count;
                off_next = s_free_address - base_reg;
            end
            ffba_pkg::ST_PREP: begin
                status_next = ffba_pkg::STATUS_OK;
                rd_act_next = 1'b1;
                carry_next = '0;
                if (cmd_reg == ffba_pkg::CMD_ALLOC) begin
                    ptr_next = '0;
                    last_word_next = LAST_WORD;
                    set_next = 1'b1;
                    if (count_ext > POOL_C) begin
                        status_next = ffba_pkg::STATUS_NOSPACE;
                    end
                end else begin
                    set_next = 1'b0;
                    start_next = free_start;
                    end_next = free_end;
                    ptr_next = free_start[WB_W +: WADDR_W];
                    last_word_next = free_last[WB_W +: WADDR_W];
                end
            end
            ffba_pkg::ST_SCAN, ffba_pkg::ST_MARK: begin
                if (rd_act_reg) begin
                    dv_next = 1'b1;
                    dw_next = ptr_reg;
                    rd_act_next = (ptr_reg != last_word_reg);
                    if (ptr_reg != last_word_reg) begin
                        ptr_next = ptr_reg + WADDR_W'(1);
                    end
                end
                if (state_reg == ffba_pkg::ST_SCAN && dv_reg) begin
                    carry_next = run_v[WORD_BITS-1];
                    if (scan_hit) begin
                        start_next = scan_start;
                        end_next = alloc_end;
                        ptr_next = scan_start[WB_W +: WADDR_W];
                        last_word_next = alloc_last[WB_W +: WADDR_W];
                        rd_act_next = 1'b1;
                        dv_next = 1'b0;
                    end else if (dw_reg == LAST_WORD) begin
                        status_next = ffba_pkg::STATUS_NOSPACE;
                    end
                end
            end
            ffba_pkg::ST_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_status_next = status_reg;
                    if (status_reg == ffba_pkg::STATUS_NOSPACE || cmd_reg == ffba_pkg::CMD_FREE) begin
                        m_addr_next = '0;
                    end else begin
                        m_addr_next = base_reg + ffba_pkg::ADDR_W'(start_reg);
                    end
                end
            end
            default: begin
                dv_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ffba_pkg::ST_CLEAR;
            ptr_reg <= '0;
            rd_act_reg <= 1'b0;
            dv_reg <= 1'b0;
            base_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ptr_reg <= ptr_next;
            rd_act_reg <= rd_act_next;
            dv_reg <= dv_next;
            base_reg <= base_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_word_reg <= last_word_next;
        dw_reg <= dw_next;
        carry_reg <= carry_next;
        cmd_reg <= cmd_next;
        count_reg <= count_next;
        off_reg <= off_next;
        start_reg <= start_next;
        end_reg <= end_next;
        set_reg <= set_next;
        status_reg <= status_next;
        m_status_reg <= m_status_next;
        m_addr_reg <= m_addr_next;
    end

    assign cfg_ready = 1'b1;
    assign m_valid = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_run_address = m_addr_reg;

    a_scan_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ffba_pkg::ST_SCAN) |-> !mem_we)
        else $error("map written during scan");

    a_result_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ffba_pkg::ST_RESP))
        else $error("result raised outside the response state");

    a_nospace_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == ffba_pkg::STATUS_NOSPACE) |-> (m_addr_reg == '0))
        else $error("failed allocation carries an address");

    a_mark_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ffba_pkg::ST_MARK && dv_reg) |-> (dw_reg <= last_word_reg))
        else $error("mark pass beyond its last word");

endmodule

// ===== verif/tb_first_fit_bitmap_allocator_core.sv =====
`timescale 1ns / 1ps

module tb_first_fit_bitmap_allocator_core;

    localparam int POOL = ffba_pkg::DEFAULT_POOL_UNITS;
    localparam int N_DIRECTED = 26;
    localparam int N_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 188;
    localparam int HOLD_AT_RESULT = 200;
    localparam int HOLD_CYCLES = 500;
    localparam int MAX_PRINTS = 40;

    typedef struct {
        logic        status;
        logic [31:0] run_address;
    } result_t;

    typedef struct {
        int unsigned off;
        int unsigned len;
    } run_t;

    typedef struct {
        logic        cmd;
        logic [10:0] cnt;
        logic [31:0] addr;
        bit          typed;
        logic        status;
        logic [31:0] run_address;
    } request_row_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic                        s_command = ffba_pkg::CMD_ALLOC;
    logic [ffba_pkg::CNT_W-1:0]  s_unit_count = '0;
    logic [ffba_pkg::ADDR_W-1:0] s_free_address = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic                        m_status;
    logic [ffba_pkg::ADDR_W-1:0] m_run_address;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [ffba_pkg::ADDR_W-1:0] cfg_data = '0;

    bit [POOL-1:0] busy_units;
    logic [31:0]   pool_base;
    result_t       pending_results[$];
    run_t          live_runs[$];
    int            err_count = 0;
    int            results_seen = 0;
    int            n_granted = 0;
    int            n_refused = 0;
    int            n_frees = 0;
    int            n_requests = 0;
    bit            calm_phase = 1'b0;

    // Directed requests, all with the pool base at its reset value of zero.
    request_row_t directed_rows [N_DIRECTED] = '{
        '{ffba_pkg::CMD_ALLOC, 11'd0,    32'hFFFF_FFFF, 1'b1, ffba_pkg::STATUS_OK,      32'd0},
        '{ffba_pkg::CMD_ALLOC, 11'd1,    32'h0000_0000, 1'b1, ffba_pkg::STATUS_OK,      32'd0},
        '{ffba_pkg::CMD_ALLOC, 11'd1024, 32'h0000_0000, 1'b1, ffba_pkg::STATUS_NOSPACE, 32'd0},
        '{ffba_pkg::CMD_ALLOC, 11'd1025, 32'h0000_0000, 1'b1, ffba_pkg::STATUS_NOSPACE, 32'd0},
        '{ffba_pkg::CMD_ALLOC, 11'd2047, 32'hFFFF_FFFF, 1'b1, ffba_pkg::STATUS_NOSPACE, 32'd0},
        '{ffba_pkg::CMD_ALLOC, 11'd0,    32'h0000_0000, 1'b0, ffba_pkg::STATUS_OK,      32'd0},
        '{ffba_pkg::CMD_ALLOC, 11'd3,    32'h0000_0000, 1'b0, ffba_pkg::STATUS_OK,      32'd0},
        '{ffba_pkg::CMD_FREE,  11'd1,    32'h0000_0000, 1'b1, ffba_pkg::STATUS_OK,      32'd0},
        '{ffba_pkg::CMD_ALLOC, 11'd1,    32'h0000_0000, 1'b0, ffba_pkg::STATUS_OK,      32'd0},
        '{ffba_pkg::CMD_FREE,  11'd5,    32'hFFFF_FFFF, 1'b1, ffba_pkg::STATUS_OK,      32'd0},
        '{ffba_pkg::CMD_FREE,  11'd2047, 32'h8000_0000, 1'b1, ffba_pkg::STATUS_OK,      32'd0},
        '{ffba_pkg::CMD_FREE,  11'd1,    32'h0000_0001, 1'b1, ffba_pkg::STATUS_OK,      32'd0},
        '{ffba_pkg::CMD_FREE,  11'd1024, 32'h0000_0000, 1'b1, ffba_pkg::STATUS_OK,      32'd0},
        '{ffba_pkg::CMD_ALLOC, 11'd1024, 32'h0000_0000, 1'b1, ffba_pkg::STATUS_OK,      32'd0},
        '{ffba_pkg::CMD_ALLOC, 11'd0,    32'h0000_0000, 1'b1, ffba_pkg::STATUS_NOSPACE, 32'd0},
        '{ffba_pkg::CMD_ALLOC, 11'd1,    32'h0000_0000, 1'b1, ffba_pkg::STATUS_NOSPACE, 32'd0},
        '{ffba_pkg::CMD_FREE,  11'd0,    32'h0000_0200, 1'b1, ffba_pkg::STATUS_OK,      32'd0},
        '{ffba_pkg::CMD_FREE,  11'd1,    32'h0000_03FF, 1'b1, ffba_pkg::STATUS_OK,      32'd0},
        '{ffba_pkg::CMD_ALLOC, 11'd2,    32'h0000_0000, 1'b0, ffba_pkg::STATUS_OK,      32'd0},
        '{ffba_pkg::CMD_ALLOC, 11'd1,    32'h0000_0000, 1'b0, ffba_pkg::STATUS_OK,      32'd0},
        '{ffba_pkg::CMD_FREE,  11'd2047, 32'h0000_03E8, 1'b1, ffba_pkg::STATUS_OK,      32'd0},
        '{ffba_pkg::CMD_ALLOC, 11'd24,   32'h0000_0000, 1'b0, ffba_pkg::STATUS_OK,      32'd0},
        '{ffba_pkg::CMD_FREE,  11'd2047, 32'h0000_0000, 1'b1, ffba_pkg::STATUS_OK,      32'd0},
        '{ffba_pkg::CMD_ALLOC, 11'd1023, 32'h0000_0000, 1'b0, ffba_pkg::STATUS_OK,      32'd0},
        '{ffba_pkg::CMD_ALLOC, 11'd2,    32'h0000_0000, 1'b0, ffba_pkg::STATUS_OK,      32'd0},
        '{ffba_pkg::CMD_FREE,  11'd1024, 32'h0000_0000, 1'b1, ffba_pkg::STATUS_OK,      32'd0}
    };

    first_fit_bitmap_allocator_core #(
        .POOL_UNITS(POOL)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_unit_count  (s_unit_count),
        .s_free_address(s_free_address),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_run_address (m_run_address),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return $urandom_range(1, 3);
        end else if (r < 96) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        if (err_count <= MAX_PRINTS) begin
            $display("MISMATCH at result %0d: %s got 0x%08h expected 0x%08h",
                     results_seen, what, got, want);
        end
    endtask

    // First-fit search and map update for one accepted transaction.
    task automatic predict_request(input logic cmd, input logic [10:0] cnt,
                                   input logic [31:0] addr, output result_t res);
        int unsigned run_len;
        int unsigned start;
        int unsigned stop;
        logic [31:0] off;
        bit          found;
        res.status = ffba_pkg::STATUS_OK;
        res.run_address = '0;
        if (cmd == ffba_pkg::CMD_ALLOC) begin
            found = 1'b0;
            run_len = 0;
            start = 0;
            if (cnt <= POOL) begin
                for (int unsigned j = 0; j < POOL && !found; j++) begin
                    if (busy_units[j]) begin
                        run_len = 0;
                    end else if (cnt == 0) begin
                        start = j;
                        found = 1'b1;
                    end else begin
                        run_len += 1;
                        if (run_len >= cnt) begin
                            start = j + 1 - cnt;
                            found = 1'b1;
                        end
                    end
                end
            end
            if (found) begin
                for (int unsigned j = start; j < start + cnt; j++) begin
                    busy_units[j] = 1'b1;
                end
                if (cnt != 0) begin
                    live_runs.push_back('{off: start, len: 32'(cnt)});
                end
                res.run_address = pool_base + start;
                n_granted++;
            end else begin
                res.status = ffba_pkg::STATUS_NOSPACE;
                n_refused++;
            end
        end else begin
            off = addr - pool_base;
            if (off < POOL) begin
                stop = off + cnt;
                if (stop > POOL) begin
                    stop = POOL;
                end
                for (int unsigned j = off; j < stop; j++) begin
                    busy_units[j] = 1'b0;
                end
            end
            n_frees++;
        end
    endtask

    task automatic send_request(input logic cmd, input logic [10:0] cnt,
                                input logic [31:0] addr, input bit typed,
                                input logic status, input logic [31:0] run_address);
        result_t want;
        s_valid <= 1'b1;
        s_command <= cmd;
        s_unit_count <= cnt;
        s_free_address <= addr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_request(cmd, cnt, addr, want);
        if (typed) begin
            want.status = status;
            want.run_address = run_address;
        end
        pending_results.push_back(want);
        n_requests++;
    endtask

    task automatic sender_gap();
        int unsigned n;
        n = (calm_phase || $urandom_range(0, 1) == 0) ? 0 : gap_len();
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic wait_all_results();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_base(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        pool_base = value;
        live_runs.delete();
    endtask

    // Most traffic allocates and then frees runs that were actually granted.
    task automatic make_random_request(output logic cmd, output logic [10:0] cnt,
                                       output logic [31:0] addr);
        int unsigned r;
        int unsigned s;
        int unsigned k;
        run_t victim;
        r = $urandom_range(0, 99);
        s = $urandom_range(0, 99);
        addr = $urandom;
        if (r < 38 || (r < 75 && live_runs.size() == 0)) begin
            cmd = ffba_pkg::CMD_ALLOC;
            if (s < 6) begin
                cnt = '0;
            end else if (s < 70) begin
                cnt = 11'($urandom_range(1, 16));
            end else if (s < 88) begin
                cnt = 11'($urandom_range(17, 128));
            end else if (s < 96) begin
                cnt = 11'($urandom_range(129, POOL));
            end else begin
                cnt = 11'($urandom_range(POOL + 1, 2047));
            end
        end else if (r < 75) begin
            cmd = ffba_pkg::CMD_FREE;
            k = $urandom_range(0, live_runs.size() - 1);
            victim = live_runs[k];
            live_runs.delete(k);
            addr = pool_base + victim.off;
            cnt = 11'(victim.len);
        end else if (r < 88) begin
            cmd = ffba_pkg::CMD_FREE;
            addr = pool_base + $urandom_range(0, POOL - 1);
            cnt = (s < 90) ? 11'($urandom_range(0, 40)) : 11'($urandom_range(41, 2047));
        end else if (r < 96) begin
            cmd = ffba_pkg::CMD_FREE;
            if (s < 50) begin
                addr = pool_base - $urandom_range(1, 4);
            end else if (s < 70) begin
                addr = pool_base + POOL + $urandom_range(0, 3);
            end
            cnt = 11'($urandom_range(0, 2047));
        end else begin
            cmd = ffba_pkg::CMD_FREE;
            addr = pool_base;
            cnt = (s < 50) ? 11'(POOL) : 11'(2047);
        end
    endtask

    initial begin : result_monitor
        int unsigned stall_left;
        result_t want;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing pending", m_run_address, 32'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_status !== want.status) begin
                        report_mismatch("status", 32'(m_status), 32'(want.status));
                    end
                    if (m_run_address !== want.run_address) begin
                        report_mismatch("run_address", m_run_address, want.run_address);
                    end
                end
                // A long hold-off lets the block fill and back up its input.
                if (results_seen == HOLD_AT_RESULT) begin
                    stall_left = HOLD_CYCLES;
                end
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                stall_left = gap_len() - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic        cmd;
        logic [10:0] cnt;
        logic [31:0] addr;
        logic [31:0] base_plan [N_PHASES];
        busy_units = '0;
        pool_base = '0;
        base_plan[0] = 32'hFFFF_FFFF;
        base_plan[1] = 32'h0000_1000;
        base_plan[2] = 32'hFFFF_FE00;
        base_plan[3] = $urandom;
        base_plan[4] = 32'h0000_0000;
        base_plan[5] = $urandom;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_request(directed_rows[i].cmd, directed_rows[i].cnt, directed_rows[i].addr,
                         directed_rows[i].typed, directed_rows[i].status,
                         directed_rows[i].run_address);
            sender_gap();
        end

        for (int p = 0; p < N_PHASES; p++) begin
            s_valid <= 1'b0;
            wait_all_results();
            write_base(base_plan[p]);
            calm_phase = (p == 3);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                make_random_request(cmd, cnt, addr);
                send_request(cmd, cnt, addr, 1'b0, ffba_pkg::STATUS_OK, 32'd0);
                if (p == 2 && i == 60) begin
                    s_valid <= 1'b0;
                    wait_all_results();
                end else begin
                    sender_gap();
                end
            end
        end

        s_valid <= 1'b0;
        wait_all_results();
        repeat (80) @(posedge aclk);
        if (pending_results.size() != 0) begin
            report_mismatch("results never delivered", pending_results.size(), 32'd0);
        end
        $display("Ran %0d requests over %0d base settings: %0d runs granted, %0d refused,",
                 n_requests, N_PHASES + 1, n_granted, n_refused);
        $display("and %0d frees, with sender and receiver stalls and one long back-pressure.",
                 n_frees);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : watchdog
        repeat (1_000_000) @(posedge aclk);
        $display("Timeout with %0d results still pending", pending_results.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
src/ffba_pkg.sv
src/first_fit_bitmap_allocator_core.sv
verif/tb_first_fit_bitmap_allocator_core.sv
